/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Sampled on the rising clock edge, off while reset is asserted.
`define SOPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Sampled on the rising clock edge, also during reset.
`define SOPS_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

/* rtl/core/sops_pkg.sv */
// ----------------------------------------------------------------------------
// Segmented odd prime sieve package
// Widths, reset values, command and status codes, shared record types.
// ----------------------------------------------------------------------------
`default_nettype none

package sops_pkg;

  localparam int unsigned PRIME_W   = 17;
  localparam int unsigned IDX_W     = 32;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned NSL_W     = 33;
  localparam int unsigned MASK_W    = 64;
  localparam int unsigned VBITS_W   = 7;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned SQ_W      = 2 * PRIME_W;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 104;

  localparam int unsigned SEGMENT_ODDS_DEF = 64;
  localparam int unsigned BASE_DEPTH_DEF   = 8192;

  localparam logic [VAL_W-1:0] MAX_VALUE_RST = 32'hFFFF_FFFD;
  localparam logic [NSL_W-1:0] SEG_LOW_RST   = 33'd3;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_LOADED   = 2'd0,
    STATUS_SIEVED   = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_PAST_MAX = 2'd3
  } status_e;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_SIEVE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic [IDX_W-1:0]   next_idx;
  } entry_t;

  typedef struct packed {
    status_e              status;
    logic [VAL_W-1:0]     segment_low;
    logic [MASK_W-1:0]    prime_mask;
    logic [VBITS_W-1:0]   valid_bits;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/segmented_odd_prime_sieve_unit.sv */
// ----------------------------------------------------------------------------
// Segmented odd prime sieve unit
// Input stream: tuser = command (0 load base prime, 1 sieve next segment),
// tdata = prime value. Output stream: tuser = status, tdata = segment low,
// prime mask, valid bit count. One result item per input item.
// One item at a time: S_DECODE, then S_LD_SQ, S_LD_WR for a load or S_SETUP,
// S_SPAN and per base prime S_RD, S_FETCH, S_TEST, S_MARK per mark step (those
// below the segment start too), S_WB for a sieve, then S_EMIT. A full store or
// a sieve past the maximum skips to S_EMIT; a tiny prime returns to S_RD, the
// prime ending the walk goes to S_FINISH. The walk is bound by the single read
// port of the base memory and the marking loop. A result waits in the output
// register while the master side stalls; the next item is taken the cycle
// after the last result has moved into that register. Reset clears the prime
// count, the next segment start (3) and the maximum (4294967293); base memory
// contents are undefined until loaded, no clearing pass is run. The maximum is
// written via cfg_we_i/cfg_wdata_i by the user only while idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_odd_prime_sieve_unit import sops_pkg::*; #(
  parameter int unsigned SEGMENT_ODDS = SEGMENT_ODDS_DEF,
  parameter int unsigned BASE_DEPTH   = BASE_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [VAL_W-1:0]      cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // [16:0] prime_value
  input  wire logic                  s_axis_tuser,  // [0] command
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]       m_axis_tdata,  // [31:0] segment_low,
                                                    // [95:32] prime_mask,
                                                    // [102:96] valid_bits
  output logic [STATUS_W-1:0]        m_axis_tuser   // [1:0] status
);

  localparam int unsigned ADDR_W = $clog2(BASE_DEPTH);

  logic              res_valid;
  logic              res_ready;
  result_t           res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  entry_t            mem_rdata;

  sops_ctrl #(
    .SEGMENT_ODDS (SEGMENT_ODDS),
    .BASE_DEPTH   (BASE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (cmd_e'(s_axis_tuser)),
    .in_prime_i  (s_axis_tdata[PRIME_W-1:0]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  sops_base_mem #(
    .DEPTH (BASE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sops_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire

/* rtl/core/sops_base_mem.sv */
// ----------------------------------------------------------------------------
// Base prime memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sops_base_mem import sops_pkg::*; #(
  parameter int unsigned DEPTH = BASE_DEPTH_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire entry_t            wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output entry_t                 rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/sops_ctrl.sv */
// ----------------------------------------------------------------------------
// Sieve sequencer
// Loads base primes, walks them per segment, marks composites one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sops_ctrl import sops_pkg::*; #(
  parameter int unsigned SEGMENT_ODDS = SEGMENT_ODDS_DEF,
  parameter int unsigned BASE_DEPTH   = BASE_DEPTH_DEF,
  localparam int unsigned ADDR_W = $clog2(BASE_DEPTH)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [VAL_W-1:0]   cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire cmd_e               in_cmd_i,
  input  wire logic [PRIME_W-1:0] in_prime_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output result_t                 res_o,
  output logic                    mem_we_o,
  output logic [ADDR_W-1:0]       mem_waddr_o,
  output entry_t                  mem_wdata_o,
  output logic                    mem_re_o,
  output logic [ADDR_W-1:0]       mem_raddr_o,
  input  wire entry_t             mem_rdata_i
);

  localparam int unsigned CNT_W     = $clog2(BASE_DEPTH + 1);
  localparam int unsigned SEG_IDX_W = $clog2(SEGMENT_ODDS);
  localparam int unsigned D_W       = IDX_W + 2;
  localparam int unsigned SPAN_ADD  = 2 * SEGMENT_ODDS - 2;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_LD_SQ  = 4'd2;
  localparam logic [3:0] S_LD_WR  = 4'd3;
  localparam logic [3:0] S_SETUP  = 4'd4;
  localparam logic [3:0] S_SPAN   = 4'd5;
  localparam logic [3:0] S_RD     = 4'd6;
  localparam logic [3:0] S_FETCH  = 4'd7;
  localparam logic [3:0] S_TEST   = 4'd8;
  localparam logic [3:0] S_MARK   = 4'd9;
  localparam logic [3:0] S_WB     = 4'd10;
  localparam logic [3:0] S_FINISH = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;

  logic [3:0]              state_q, state_d;
  logic [VAL_W-1:0]        max_q, max_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [NSL_W-1:0]        nsl_q, nsl_d;

  cmd_e                    cmd_q, cmd_d;
  logic [PRIME_W-1:0]      pv_q, pv_d;
  logic [VAL_W-1:0]        high_q, high_d;
  logic [IDX_W-1:0]        a0_q, a0_d;
  logic [VBITS_W-1:0]      nodds_q, nodds_d;
  logic [SEGMENT_ODDS-1:0] marked_q, marked_d;
  logic [CNT_W-1:0]        k_q, k_d;
  logic [PRIME_W-1:0]      p_q, p_d;
  logic [SQ_W-1:0]         sq_q, sq_d;
  logic [D_W-1:0]          d_q, d_d;
  result_t                 res_q, res_d;

  logic [PRIME_W-1:0]      mul_op;
  logic [SQ_W-1:0]         sq_prod;
  logic [NSL_W-1:0]        span_top;
  logic [VAL_W-1:0]        span_diff;
  logic [SEGMENT_ODDS-1:0] vmask;

  assign mul_op  = (state_q == S_FETCH) ? mem_rdata_i.prime : pv_q;
  assign sq_prod = SQ_W'(mul_op) * SQ_W'(mul_op);

  assign span_top  = nsl_q + NSL_W'(SPAN_ADD);
  assign span_diff = high_q - nsl_q[VAL_W-1:0];

  always_comb begin
    for (int i = 0; i < SEGMENT_ODDS; i++) begin
      vmask[i] = (VBITS_W'(i) < nodds_q);
    end
  end

  always_comb begin
    state_d  = state_q;
    max_d    = max_q;
    count_d  = count_q;
    nsl_d    = nsl_q;
    cmd_d    = cmd_q;
    pv_d     = pv_q;
    high_d   = high_q;
    a0_d     = a0_q;
    nodds_d  = nodds_q;
    marked_d = marked_q;
    k_d      = k_q;
    p_d      = p_q;
    sq_d     = sq_q;
    d_d      = d_q;
    res_d    = res_q;

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = k_q[ADDR_W-1:0];
    mem_wdata_o = '{prime: p_q, next_idx: IDX_W'(d_q + D_W'(a0_q))};
    mem_re_o    = 1'b0;
    mem_raddr_o = k_q[ADDR_W-1:0];

    if (cfg_we_i) begin
      max_d = cfg_wdata_i;
    end

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d   = in_cmd_i;
          pv_d    = in_prime_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        res_d = '0;
        if (cmd_q == CMD_LOAD) begin
          if (count_q == CNT_W'(BASE_DEPTH)) begin
            res_d.status = STATUS_FULL;
            state_d      = S_EMIT;
          end else begin
            state_d = S_LD_SQ;
          end
        end else if (nsl_q > NSL_W'(max_q)) begin
          res_d.status = STATUS_PAST_MAX;
          state_d      = S_EMIT;
        end else begin
          high_d  = (span_top > NSL_W'(max_q)) ? max_q : span_top[VAL_W-1:0];
          state_d = S_SETUP;
        end
      end
      S_LD_SQ: begin
        sq_d    = sq_prod;
        state_d = S_LD_WR;
      end
      S_LD_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = count_q[ADDR_W-1:0];
        mem_wdata_o.prime    = pv_q;
        mem_wdata_o.next_idx = (pv_q >= PRIME_W'(3)) ?
                               IDX_W'((sq_q - SQ_W'(3)) >> 1) : '0;
        count_d      = count_q + CNT_W'(1);
        res_d.status = STATUS_LOADED;
        state_d      = S_EMIT;
      end
      S_SETUP: begin
        // even top steps down to the last odd value
        high_d  = high_q[0] ? high_q : high_q - VAL_W'(1);
        a0_d    = IDX_W'((nsl_q - NSL_W'(3)) >> 1);
        state_d = S_SPAN;
      end
      S_SPAN: begin
        nodds_d  = VBITS_W'(span_diff >> 1) + VBITS_W'(1);
        marked_d = '0;
        k_d      = '0;
        state_d  = S_RD;
      end
      S_RD: begin
        if (k_q == count_q) begin
          state_d = S_FINISH;
        end else begin
          mem_re_o = 1'b1;
          state_d  = S_FETCH;
        end
      end
      S_FETCH: begin
        p_d     = mem_rdata_i.prime;
        d_d     = D_W'(mem_rdata_i.next_idx) - D_W'(a0_q);
        sq_d    = sq_prod;
        state_d = S_TEST;
      end
      S_TEST: begin
        if (p_q < PRIME_W'(3)) begin
          k_d     = k_q + CNT_W'(1);
          state_d = S_RD;
        end else if (sq_q > SQ_W'(high_q)) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_MARK;
        end
      end
      S_MARK: begin
        // d is the signed offset of the next mark from the segment start
        if (!d_q[D_W-1] && (d_q >= D_W'(nodds_q))) begin
          state_d = S_WB;
        end else begin
          if (!d_q[D_W-1]) begin
            marked_d[d_q[SEG_IDX_W-1:0]] = 1'b1;
          end
          d_d = d_q + D_W'(p_q);
        end
      end
      S_WB: begin
        mem_we_o = 1'b1;
        k_d      = k_q + CNT_W'(1);
        state_d  = S_RD;
      end
      S_FINISH: begin
        res_d.status      = STATUS_SIEVED;
        res_d.segment_low = nsl_q[VAL_W-1:0];
        res_d.prime_mask  = MASK_W'(~marked_q & vmask);
        res_d.valid_bits  = nodds_q;
        nsl_d             = NSL_W'(high_q) + NSL_W'(2);
        state_d           = S_EMIT;
      end
      S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      max_q   <= MAX_VALUE_RST;
      count_q <= '0;
      nsl_q   <= SEG_LOW_RST;
    end else begin
      state_q <= state_d;
      max_q   <= max_d;
      count_q <= count_d;
      nsl_q   <= nsl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    pv_q     <= pv_d;
    high_q   <= high_d;
    a0_q     <= a0_d;
    nodds_q  <= nodds_d;
    marked_q <= marked_d;
    k_q      <= k_d;
    p_q      <= p_d;
    sq_q     <= sq_d;
    d_q      <= d_d;
    res_q    <= res_d;
  end

endmodule

`default_nettype wire

/* rtl/core/sops_out_reg.sv */
// ----------------------------------------------------------------------------
// Result output register
// Holds one result item for the master stream and packs it onto tdata/tuser.
// ----------------------------------------------------------------------------
`default_nettype none

module sops_out_reg import sops_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 res_valid_i,
  output logic                      res_ready_o,
  input  wire result_t              res_i,
  output logic                      m_tvalid_o,
  input  wire logic                 m_tready_i,
  output logic [M_TDATA_W-1:0]      m_tdata_o,
  output logic [STATUS_W-1:0]       m_tuser_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign res_ready_o = !valid_q || m_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = {1'b0, data_q.valid_bits, data_q.prime_mask, data_q.segment_low};
  assign m_tuser_o  = data_q.status;

endmodule

`default_nettype wire

/* rtl/core/sops_checker.sv */
// ----------------------------------------------------------------------------
// Sieve unit port checker
// Concurrent checks on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sops_checker import sops_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input wire logic [STATUS_W-1:0]  m_axis_tuser
);

  `SOPS_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output item changed while stalled")

  `SOPS_ASSERT(a_one_item, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while an item is in work")

  `SOPS_ASSERT(a_zero_payload, m_axis_tvalid && m_axis_tuser != STATUS_SIEVED |-> m_axis_tdata == '0, "nonzero payload on a non-segment result")

  `SOPS_ASSERT(a_seg_shape, m_axis_tvalid && m_axis_tuser == STATUS_SIEVED |-> m_axis_tdata[0] && m_axis_tdata[VAL_W+MASK_W +: VBITS_W] != '0, "segment result with even low or empty span")

  `SOPS_ASSERT_NR(a_reset_clear, !rst_ni |=> !m_axis_tvalid, "output valid right after reset")

endmodule

bind segmented_odd_prime_sieve_unit sops_checker u_sops_checker (.*);

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Segmented odd prime sieve unit testbench
// Drives load and sieve commands through the input stream and checks every
// result item against an in-bench sieve predictor. The run steps through
// several maximum settings and loads wide and out-of-range base values.
// Random bursts on the input side and random stalls on the output side are
// applied.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import sops_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned IDLE_WAIT    = 8;
  localparam logic [VAL_W-1:0] MAX_TOP = 32'hFFFF_FFFD;
  localparam logic [VAL_W-1:0] MAX_LOW = 32'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [VAL_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  segmented_odd_prime_sieve_unit u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  // predictor state
  logic [PRIME_W-1:0] prime_tab [BASE_DEPTH_DEF];
  logic [IDX_W-1:0]   mark_tab  [BASE_DEPTH_DEF];
  int unsigned        prime_cnt = 0;
  logic [NSL_W-1:0]   seg_low_next = SEG_LOW_RST;
  logic [VAL_W-1:0]   max_val = MAX_VALUE_RST;

  result_t     sieve_exp_q [$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned seen_loaded = 0, seen_sieved = 0, seen_full = 0, seen_past = 0;
  int unsigned burst_left = 0;
  int unsigned next_p = 1;

  function automatic result_t sieve_predict(input cmd_e cmd, input logic [PRIME_W-1:0] pv);
    result_t r;
    logic [63:0] low, high, a0, n_odds, a_end, j, p, d, marked, vmask;
    r = '0;
    if (cmd == CMD_LOAD) begin
      if (prime_cnt >= BASE_DEPTH_DEF) begin
        r.status = STATUS_FULL;
        return r;
      end
      prime_tab[prime_cnt] = pv;
      if (pv >= 3) begin
        p = 64'(pv);
        d = (p * p - 64'd3) >> 1;
        mark_tab[prime_cnt] = d[31:0];
      end else begin
        mark_tab[prime_cnt] = '0;
      end
      prime_cnt++;
      r.status = STATUS_LOADED;
      return r;
    end
    low = 64'(seg_low_next);
    if (low > 64'(max_val)) begin
      r.status = STATUS_PAST_MAX;
      return r;
    end
    high = low + 2 * SEGMENT_ODDS_DEF - 2;
    if (high > 64'(max_val)) high = 64'(max_val);
    if (!high[0]) high = high - 1;
    if (high < low) begin
      r.status = STATUS_PAST_MAX;
      return r;
    end
    a0 = (low - 3) >> 1;
    n_odds = ((high - low) >> 1) + 1;
    a_end = a0 + n_odds;
    marked = '0;
    for (int unsigned k = 0; k < prime_cnt; k++) begin
      p = 64'(prime_tab[k]);
      if (p < 3) continue;
      if (p * p > high) break;
      j = 64'(mark_tab[k]);
      if (j >= a_end) continue;
      while (j < a_end) begin
        if (j >= a0) begin
          d = j - a0;
          marked[d[5:0]] = 1'b1;
        end
        j = j + p;
      end
      mark_tab[k] = j[31:0];
    end
    vmask = (n_odds >= 64) ? '1 : ((64'd1 << n_odds) - 64'd1);
    seg_low_next = 33'(high + 2);
    r.status = STATUS_SIEVED;
    r.segment_low = low[31:0];
    r.prime_mask = ~marked & vmask;
    r.valid_bits = n_odds[6:0];
    return r;
  endfunction

  function automatic bit is_prime(input int unsigned n);
    if (n < 2) return 1'b0;
    for (int unsigned dv = 2; dv * dv <= n; dv++)
      if (n % dv == 0) return 1'b0;
    return 1'b1;
  endfunction

  // bursts with random gaps; tvalid is only lowered on a gap or when draining
  task automatic send_item(input cmd_e cmd, input logic [PRIME_W-1:0] pv);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= S_TDATA_W'(pv);
    sieve_exp_q.push_back(sieve_predict(cmd, pv));
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sieve_exp_q.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_max_value(input logic [VAL_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    max_val = v;
  endtask

  task automatic load_next_prime();
    next_p = (next_p < 3) ? 3 : next_p + 2;
    while (!is_prime(next_p)) next_p += 2;
    send_item(CMD_LOAD, PRIME_W'(next_p));
  endtask

  // output side stall pattern
  int unsigned stall_cnt = 0;
  int unsigned stall_mode = 0;
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt  <= $urandom_range(16, 96);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= stall_cnt[2];
    endcase
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && m_tvalid && m_tready) begin
      if (sieve_exp_q.size() == 0) begin
        $error("result item with no expectation: status %0d", m_tuser);
        err_cnt++;
      end else begin
        exp_r = sieve_exp_q.pop_front();
        case (status_e'(m_tuser))
          STATUS_LOADED:   seen_loaded++;
          STATUS_SIEVED:   seen_sieved++;
          STATUS_FULL:     seen_full++;
          STATUS_PAST_MAX: seen_past++;
          default: ;
        endcase
        if (m_tuser !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
          err_cnt++;
        end
        if (m_tdata[31:0] !== exp_r.segment_low) begin
          $error("segment_low: expected %0d, got %0d", exp_r.segment_low, m_tdata[31:0]);
          err_cnt++;
        end
        if (m_tdata[95:32] !== exp_r.prime_mask) begin
          $error("prime_mask: expected %h, got %h", exp_r.prime_mask, m_tdata[95:32]);
          err_cnt++;
        end
        if (m_tdata[102:96] !== exp_r.valid_bits) begin
          $error("valid_bits: expected %0d, got %0d", exp_r.valid_bits, m_tdata[102:96]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_empty_store();
    send_item(CMD_SIEVE, '0);
    send_item(CMD_SIEVE, '0);
  endtask

  task automatic test_tiny_loads();
    send_item(CMD_LOAD, 17'd0);
    send_item(CMD_LOAD, 17'd1);
    send_item(CMD_LOAD, 17'd2);
  endtask

  task automatic test_first_segments();
    repeat (5) load_next_prime();
    repeat (3) send_item(CMD_SIEVE, '0);
  endtask

  // odd low plus an odd offset gives an even maximum
  task automatic test_even_max();
    write_max_value(VAL_W'(seg_low_next) + 32'd21);
    send_item(CMD_SIEVE, '0);
    send_item(CMD_SIEVE, '0);
  endtask

  task automatic test_max_extremes();
    write_max_value(MAX_LOW);
    send_item(CMD_SIEVE, '0);
    send_item(CMD_LOAD, 17'h1FFFF & 17'd7);
    write_max_value(MAX_TOP);
    send_item(CMD_SIEVE, '0);
    send_item(CMD_SIEVE, '0);
  endtask

  task automatic test_random_mix();
    int unsigned sel;
    logic [PRIME_W-1:0] pv;
    for (int rnd = 0; rnd < 4; rnd++) begin
      case (rnd)
        0: write_max_value(MAX_TOP);
        1: write_max_value(VAL_W'(seg_low_next) + VAL_W'($urandom_range(0, 900)));
        2: write_max_value(VAL_W'($urandom_range(3, 32'hFFFF_FFFD)));
        default: write_max_value(MAX_TOP);
      endcase
      repeat (18) begin
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
          load_next_prime();
        end else if (sel < 85) begin
          send_item(CMD_SIEVE, PRIME_W'($urandom));
        end else begin
          case ($urandom_range(0, 2))
            0: pv = PRIME_W'($urandom_range(0, 2));
            1: pv = PRIME_W'($urandom_range(4, 100) * 2 + 1);
            default: pv = prime_tab[$urandom_range(0, prime_cnt - 1)];
          endcase
          send_item(CMD_LOAD, pv);
        end
      end
    end
  endtask

  // squares near and past 32 bits, including the widest input value
  task automatic test_wide_loads();
    send_item(CMD_LOAD, 17'd65521);
    send_item(CMD_LOAD, 17'd65537);
    send_item(CMD_LOAD, 17'h1FFFF);
    send_item(CMD_LOAD, PRIME_W'($urandom_range(0, 65537)));
    repeat (2) send_item(CMD_SIEVE, '0);
    write_max_value(MAX_LOW);
    send_item(CMD_LOAD, 17'd3);
    send_item(CMD_SIEVE, '0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_empty_store();
    test_tiny_loads();
    test_first_segments();
    test_even_max();
    test_max_extremes();
    test_random_mix();
    test_wide_loads();
    wait_idle();
    repeat (20) @(posedge clk);
    $display("Covered %0d loads, %0d loads into a full store, %0d sieved segments,",
             seen_loaded, seen_full, seen_sieved);
    $display("%0d past-maximum replies, %0d base entries held", seen_past, prime_cnt);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
